// File: hdl/ptc_pkg.sv
package ptc_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  localparam logic [1:0] REG_TEMP       = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] REG_PRESS_MID  = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

  localparam logic [19:0] NO_CONVERSION = 20'h80000;

  localparam logic signed [63:0] SAT_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN  = 64'sh8000_0000_0000_0001;
  localparam logic signed [64:0] SAT_HI65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LO65 = 65'sh1_8000_0000_0000_0001;

  localparam logic signed [63:0] Q_ONE    = 64'sd16777216;
  localparam logic signed [63:0] V_OFFSET = -64'sd1073741824000;
  localparam logic signed [63:0] K_6250   = 64'sd6250;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic [1:0]         result_status;
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q8;
  } result_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  function automatic logic [63:0] mag(logic signed [63:0] x);
    return x[63] ? unsigned'(-x) : unsigned'(x);
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > SAT_HI65) return SAT_MAX;
    else if (s < SAT_LO65) return SAT_MIN;
    else return s[63:0];
  endfunction

  // signed shift right, rounding toward zero
  function automatic logic signed [63:0] trunc_shr(logic signed [63:0] x, int unsigned sh);
    logic [63:0] m;
    m = mag(x) >> sh;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sx16(logic [15:0] w);
    return $signed({{48{w[15]}}, w});
  endfunction

endpackage

// File: hdl/ptc_mul.sv
module ptc_mul import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic [5:0]         sh_i,
  output logic signed [63:0] p_o
);

  logic        neg1_q, neg2_q, neg3_q;
  logic [5:0]  sh1_q, sh2_q, sh3_q;
  logic [63:0] ua_q, ub_q;
  logic [63:0] p00_q, p01_q, p10_q, p11_q;
  logic [127:0] full_q;
  logic signed [63:0] p_q, p_d;
  logic [127:0] shifted;

  always_comb begin
    shifted = full_q >> sh3_q;
    if (|shifted[127:63]) begin
      p_d = neg3_q ? SAT_MIN : SAT_MAX;
    end else if (neg3_q) begin
      p_d = -$signed({1'b0, shifted[62:0]});
    end else begin
      p_d = $signed({1'b0, shifted[62:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[63] ^ b_i[63];
    sh1_q  <= sh_i;
    ua_q   <= mag(a_i);
    ub_q   <= mag(b_i);
    // partial products
    neg2_q <= neg1_q;
    sh2_q  <= sh1_q;
    p00_q  <= 64'(ua_q[31:0])  * 64'(ub_q[31:0]);
    p01_q  <= 64'(ua_q[31:0])  * 64'(ub_q[63:32]);
    p10_q  <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
    p11_q  <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
    neg3_q <= neg2_q;
    sh3_q  <= sh2_q;
    full_q <= {64'b0, p00_q} + {32'b0, p01_q, 32'b0} + {32'b0, p10_q, 32'b0}
              + {p11_q, 64'b0};
    p_q    <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: hdl/ptc_div.sv
module ptc_div import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic signed [63:0] q_o
);

  localparam int Steps = 63;
  localparam int FracBits = 24;

  logic [62:0] un_q  [0:Steps];
  logic [62:0] ud_q  [0:Steps];
  logic [62:0] rem_q [0:Steps];
  logic [62:0] quo_q [0:Steps];
  logic        neg_q [0:Steps];
  logic        ovf_q [0:Steps];
  logic [63:0] un_m, ud_m;
  logic [62:0] un_d, ud_d;
  logic signed [63:0] q_q, q_d;

  assign un_m = mag(n_i);
  assign ud_m = mag(d_i);
  assign un_d = un_m[62:0];
  assign ud_d = ud_m[62:0];

  always_ff @(posedge clk_i) begin
    un_q[0]  <= un_d;
    ud_q[0]  <= ud_d;
    rem_q[0] <= {39'b0, un_d[62:39]};
    quo_q[0] <= '0;
    neg_q[0] <= n_i[63] ^ d_i[63];
    ovf_q[0] <= ({39'b0, un_d[62:39]} >= ud_d);
  end

  for (genvar j = 1; j <= Steps; j++) begin : g_step
    localparam int Bit = Steps - j;
    logic        dbit;
    logic [63:0] rem2;
    logic [63:0] diff;
    if (Bit >= FracBits) begin : g_num
      assign dbit = un_q[j-1][Bit-FracBits];
    end else begin : g_zero
      assign dbit = 1'b0;
    end
    assign rem2 = {rem_q[j-1], dbit};
    assign diff = rem2 - {1'b0, ud_q[j-1]};
    always_ff @(posedge clk_i) begin
      un_q[j]  <= un_q[j-1];
      ud_q[j]  <= ud_q[j-1];
      neg_q[j] <= neg_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
      if (rem2 >= {1'b0, ud_q[j-1]}) begin
        rem_q[j] <= diff[62:0];
        quo_q[j] <= {quo_q[j-1][61:0], 1'b1};
      end else begin
        rem_q[j] <= rem2[62:0];
        quo_q[j] <= {quo_q[j-1][61:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (ovf_q[Steps]) begin
      q_d = neg_q[Steps] ? SAT_MIN : SAT_MAX;
    end else if (neg_q[Steps]) begin
      q_d = -$signed({1'b0, quo_q[Steps]});
    end else begin
      q_d = $signed({1'b0, quo_q[Steps]});
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

// File: hdl/ptc_core.sv
module ptc_core import ptc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  sample_t sample_i,
  input  coef_t   coef_i,
  output logic    valid_o,
  output result_t result_o
);

  logic [97:0]  vld_q;
  logic [96:0]  nc_q;
  logic [96:21] dz_q;
  logic [19:0]  adcp_q [0:15];
  logic [19:0]  adct_q;
  logic signed [15:0] centi_q [5:96];
  logic signed [63:0] v_q [5:9];
  logic signed [63:0] p_q [86:95];

  logic signed [21:0] n1_q;
  logic signed [37:0] n1t2_q;
  logic signed [43:0] nn_q;
  logic signed [63:0] ta_q;
  logic signed [59:0] tb_q;
  logic signed [63:0] tf_q;
  logic signed [63:0] t5x, cfull;
  logic signed [15:0] centi_d;

  logic signed [63:0] vv_w, vb1_w, va1_w, vb2_w, va2_w;
  logic signed [63:0] vbs_q, vas_q, vbt_q, vat_q, dsum_q, nsum_q;
  logic signed [63:0] p0_w;
  logic signed [63:0] den_w, num_w, pdiv_w;
  logic signed [63:0] pp_w, c1_w, c2_w;
  logic signed [63:0] corr1_q, corr2_q, pf_q;
  logic [63:0]  pround;
  logic [31:0]  pq8_d;
  result_t      res_q, res_d;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[96:0], valid_i};
    end
  end

  // temperature and front end
  always_comb begin
    t5x = (tf_q <<< 2) + tf_q + 64'sh200_0000_0000;
    cfull = t5x >>> 42;
    if (cfull > 64'sd32767) begin
      centi_d = 16'sh7FFF;
    end else if (cfull < -64'sd32768) begin
      centi_d = 16'sh8000;
    end else begin
      centi_d = cfull[15:0];
    end
  end

  assign p0_w = $signed({19'b0, 21'h100000 - {1'b0, adcp_q[15]}, 24'b0});

  always_ff @(posedge clk_i) begin
    adcp_q[0] <= sample_i.raw_pressure;
    adct_q    <= sample_i.raw_temperature;
    nc_q      <= {nc_q[95:0], (sample_i.raw_pressure == NO_CONVERSION)
                               || (sample_i.raw_temperature == NO_CONVERSION)};
    for (int k = 1; k <= 15; k++) adcp_q[k] <= adcp_q[k-1];

    n1_q   <= $signed({2'b0, adct_q}) - $signed({2'b0, coef_i.t1, 4'b0});
    n1t2_q <= n1_q * $signed(coef_i.t2);
    nn_q   <= n1_q * n1_q;
    ta_q   <= $signed({{6{n1t2_q[37]}}, n1t2_q, 20'b0});
    tb_q   <= nn_q * $signed(coef_i.t3);
    tf_q   <= ta_q + 64'(tb_q);

    centi_q[5] <= centi_d;
    for (int k = 6; k <= 96; k++) centi_q[k] <= centi_q[k-1];
    v_q[5] <= sat_add(trunc_shr(tf_q, 11), V_OFFSET);
    for (int k = 6; k <= 9; k++) v_q[k] <= v_q[k-1];

    vbs_q  <= sat_add(vb1_w, vb2_w);
    vas_q  <= sat_add(va1_w, va2_w);
    vbt_q  <= sat_add(trunc_shr(vbs_q, 2), $signed({{8{coef_i.p4[15]}}, coef_i.p4, 40'b0}));
    vat_q  <= trunc_shr(vas_q, 19);
    dsum_q <= sat_add(Q_ONE, trunc_shr(vat_q, 15));
    nsum_q <= sat_add(p0_w, -trunc_shr(vbt_q, 12));

    dz_q <= {dz_q[95:21], den_w == '0};

    p_q[86] <= pdiv_w;
    for (int k = 87; k <= 95; k++) p_q[k] <= p_q[k-1];
    corr1_q <= sat_add(c1_w, c2_w);
    corr2_q <= sat_add(corr1_q, $signed({{24{coef_i.p7[15]}}, coef_i.p7, 24'b0}));
    pf_q    <= sat_add(p_q[95], trunc_shr(corr2_q, 4));
    res_q   <= res_d;
  end

  // pressure chain
  ptc_mul u_mul_vv (.clk_i, .a_i(v_q[5]), .b_i(v_q[5]), .sh_i(6'd24), .p_o(vv_w));
  ptc_mul u_mul_vb1 (.clk_i, .a_i(vv_w), .b_i(sx16(coef_i.p6)), .sh_i(6'd15), .p_o(vb1_w));
  ptc_mul u_mul_va1 (.clk_i, .a_i(vv_w), .b_i(sx16(coef_i.p3)), .sh_i(6'd19), .p_o(va1_w));
  ptc_mul u_mul_vb2 (
    .clk_i,
    .a_i (v_q[9]),
    .b_i ($signed({{47{coef_i.p5[15]}}, coef_i.p5, 1'b0})),
    .sh_i(6'd0),
    .p_o (vb2_w)
  );
  ptc_mul u_mul_va2 (.clk_i, .a_i(v_q[9]), .b_i(sx16(coef_i.p2)), .sh_i(6'd0), .p_o(va2_w));
  ptc_mul u_mul_den (
    .clk_i,
    .a_i (dsum_q),
    .b_i ($signed({48'b0, coef_i.p1})),
    .sh_i(6'd0),
    .p_o (den_w)
  );
  ptc_mul u_mul_num (.clk_i, .a_i(nsum_q), .b_i(K_6250), .sh_i(6'd0), .p_o(num_w));

  ptc_div u_div (.clk_i, .n_i(num_w), .d_i(den_w), .q_o(pdiv_w));

  ptc_mul u_mul_pp (.clk_i, .a_i(pdiv_w), .b_i(pdiv_w), .sh_i(6'd24), .p_o(pp_w));
  ptc_mul u_mul_c1 (.clk_i, .a_i(pp_w), .b_i(sx16(coef_i.p9)), .sh_i(6'd31), .p_o(c1_w));
  ptc_mul u_mul_c2 (.clk_i, .a_i(p_q[89]), .b_i(sx16(coef_i.p8)), .sh_i(6'd15), .p_o(c2_w));

  // output rounding and status
  always_comb begin
    pround = unsigned'(pf_q) + 64'd32768;
    if (pf_q <= 64'sd0) begin
      pq8_d = '0;
    end else if (|pround[63:48]) begin
      pq8_d = 32'hFFFF_FFFF;
    end else begin
      pq8_d = pround[47:16];
    end
    res_d.result_status     = ST_OK;
    res_d.temperature_centi = centi_q[96];
    res_d.pressure_q8       = pq8_d;
    if (nc_q[96]) begin
      res_d.result_status     = ST_BUSY;
      res_d.temperature_centi = '0;
      res_d.pressure_q8       = '0;
    end else if (dz_q[96]) begin
      res_d.result_status = ST_DIV_ZERO;
      res_d.pressure_q8   = '0;
    end
  end

  assign valid_o  = vld_q[97];
  assign result_o = res_q;

endmodule

// File: hdl/pressure_temperature_compensation_top.sv
// throughput: one beat per cycle, set by the fully pipelined datapath and the
//   63-stage restoring divider; busy is low except in the first cycle after reset
// the receiver cannot stall: each result is shown for exactly one cycle
// reset clears the calibration registers to zero and empties the pipeline
module pressure_temperature_compensation_top import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] temp_q, plow_q, pmid_q, phigh_q;
  logic        busy_q;
  coef_t       coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      plow_q  <= '0;
      pmid_q  <= '0;
      phigh_q <= '0;
      busy_q  <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TEMP:       temp_q  <= cfg_data_i;
          REG_PRESS_LOW:  plow_q  <= cfg_data_i;
          REG_PRESS_MID:  pmid_q  <= cfg_data_i;
          REG_PRESS_HIGH: phigh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign coef = '{
    t1: temp_q[15:0],  t2: temp_q[31:16],  t3: temp_q[47:32],
    p1: plow_q[15:0],  p2: plow_q[31:16],  p3: plow_q[47:32],
    p4: pmid_q[15:0],  p5: pmid_q[31:16],  p6: pmid_q[47:32],
    p7: phigh_q[15:0], p8: phigh_q[31:16], p9: phigh_q[47:32]
  };

  assign busy = busy_q;

  ptc_core u_core (
    .clk_i,
    .rst_ni,
    .valid_i (start && !busy_q),
    .sample_i,
    .coef_i  (coef),
    .valid_o (result_valid_o),
    .result_o
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 110;
  localparam longint QONE = 64'sd16777216;
  localparam longint QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  sample_t     sample_i = '0;
  logic        result_valid_o;
  result_t     result_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_TEMP;
  logic [47:0] cfg_data_i = '0;

  logic [47:0] coeff_regs [4];
  result_t     pending_results [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;

  pressure_temperature_compensation_top dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL pressure_temperature_compensation_top");
      $finish;
    end
  end

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(QMAX)) return QMAX;
    if (s < -65'(QMAX)) return -QMAX;
    return longint'(s[63:0]);
  endfunction

  function automatic longint scaled_mul(longint a, longint b, int sh);
    logic [127:0] prod;
    logic [63:0]  ua, ub;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = ({64'b0, ua} * {64'b0, ub}) >> sh;
    if (prod > 128'(QMAX)) return neg ? -QMAX : QMAX;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint frac_div(longint n, longint d);
    logic [127:0] q;
    logic [63:0]  un, ud;
    bit neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    if (ud == 0) return neg ? -QMAX : QMAX;
    if (un / ud > (64'(QMAX) >> 24)) return neg ? -QMAX : QMAX;
    q = ({64'b0, un} << 24) / {64'b0, ud};
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint sword(logic [47:0] r, int pos);
    logic [15:0] w;
    w = r[pos +: 16];
    return longint'($signed(w));
  endfunction

  function automatic longint uword(logic [47:0] r, int pos);
    return longint'({48'b0, r[pos +: 16]});
  endfunction

  function automatic result_t compensate(sample_t s);
    result_t r;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint n1, tf, centi, v, vv, va, vb, den, p, num, corr;
    logic [63:0] pq;
    r = '0;
    if (s.raw_pressure == NO_CONVERSION || s.raw_temperature == NO_CONVERSION) begin
      r.result_status = ST_BUSY;
      return r;
    end
    t1 = uword(coeff_regs[0], 0); t2 = sword(coeff_regs[0], 16); t3 = sword(coeff_regs[0], 32);
    p1 = uword(coeff_regs[1], 0); p2 = sword(coeff_regs[1], 16); p3 = sword(coeff_regs[1], 32);
    p4 = sword(coeff_regs[2], 0); p5 = sword(coeff_regs[2], 16); p6 = sword(coeff_regs[2], 32);
    p7 = sword(coeff_regs[3], 0); p8 = sword(coeff_regs[3], 16); p9 = sword(coeff_regs[3], 32);
    n1 = longint'({44'b0, s.raw_temperature}) - 16 * t1;
    tf = n1 * t2 * 64'sd1048576 + n1 * n1 * t3;
    centi = (tf * 5 + (64'sd1 <<< 41)) >>> 42;
    if (centi > 32767) centi = 32767;
    if (centi < -32768) centi = -32768;
    r.temperature_centi = centi[15:0];
    v = sat_sum(scaled_mul(tf, 1, 11), -64'sd64000 * QONE);
    vv = scaled_mul(v, v, 24);
    vb = scaled_mul(vv, p6, 15);
    vb = sat_sum(vb, scaled_mul(v, 2 * p5, 0));
    vb = sat_sum(scaled_mul(vb, 1, 2), p4 * (64'sd1 <<< 40));
    va = sat_sum(scaled_mul(vv, p3, 19), scaled_mul(v, p2, 0));
    va = scaled_mul(va, 1, 19);
    den = scaled_mul(sat_sum(QONE, scaled_mul(va, 1, 15)), p1, 0);
    if (den == 0) begin
      r.result_status = ST_DIV_ZERO;
      return r;
    end
    p = (64'sd1048576 - longint'({44'b0, s.raw_pressure})) * QONE;
    num = scaled_mul(sat_sum(p, -scaled_mul(vb, 1, 12)), 6250, 0);
    p = frac_div(num, den);
    corr = sat_sum(scaled_mul(scaled_mul(p, p, 24), p9, 31), scaled_mul(p, p8, 15));
    corr = sat_sum(corr, p7 * QONE);
    p = sat_sum(p, scaled_mul(corr, 1, 4));
    r.result_status = ST_OK;
    if (p > 0) begin
      pq = (64'(p) + 64'd32768) >> 16;
      r.pressure_q8 = (pq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pq[31:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %p", $realtime, result_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.result_status !== want.result_status) begin
          $display("%0t status: expected %0d actual %0d", $realtime,
                   want.result_status, result_o.result_status);
          mismatches++;
        end
        if (result_o.temperature_centi !== want.temperature_centi) begin
          $display("%0t temperature: expected %0d actual %0d", $realtime,
                   want.temperature_centi, result_o.temperature_centi);
          mismatches++;
        end
        if (result_o.pressure_q8 !== want.pressure_q8) begin
          $display("%0t pressure: expected %0d actual %0d", $realtime,
                   want.pressure_q8, result_o.pressure_q8);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(logic [19:0] rp, logic [19:0] rt);
    sample_t s;
    s.raw_pressure = rp;
    s.raw_temperature = rt;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(compensate(s));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_coeffs(logic [47:0] tc, logic [47:0] pl, logic [47:0] pm,
                              logic [47:0] ph);
    logic [47:0] vals [4];
    vals = '{tc, pl, pm, ph};
    wait_drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      coeff_regs[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic typical_coeffs();
    write_coeffs({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
  endtask

  task automatic jitter_coeffs();
    logic [15:0] w [12];
    w = '{16'd27504, 16'd26435, 16'hFC18, 16'd36477, 16'hD643, 16'd3024,
          16'd2855, 16'd140, 16'hFFF9, 16'd15500, 16'hC6F8, 16'd6000};
    for (int i = 0; i < 12; i++) w[i] = w[i] + 16'($urandom_range(0, 64)) - 16'd32;
    write_coeffs({w[2], w[1], w[0]}, {w[5], w[4], w[3]}, {w[8], w[7], w[6]},
                 {w[11], w[10], w[9]});
  endtask

  task automatic random_sample();
    int k;
    k = $urandom_range(99);
    if (k < 3) send_sample(NO_CONVERSION, 20'($urandom));
    else if (k < 6) send_sample(20'($urandom), NO_CONVERSION);
    else if (k < 25) send_sample(20'($urandom), 20'($urandom));
    else send_sample(20'($urandom_range(200000, 600000)), 20'($urandom_range(400000, 600000)));
  endtask

  task automatic test_reset_state();
    send_sample(20'd415148, 20'd519888);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(NO_CONVERSION, 20'd1);
  endtask

  task automatic test_directed();
    typical_coeffs();
    send_sample(20'd415148, 20'd519888);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(NO_CONVERSION, 20'd519888);
    send_sample(20'd415148, NO_CONVERSION);
    send_sample(NO_CONVERSION, NO_CONVERSION);
    send_sample(20'h7FFFF, 20'h80001);
    write_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd415148, 20'd519888);
    write_coeffs({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h0001},
                 {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd415148, 20'd519888);
    write_coeffs('1, '1, '1, '1);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'd415148, 20'd519888);
    // zero divisor with a live temperature
    write_coeffs({16'hFC18, 16'd26435, 16'd27504}, '0, '0, '0);
    send_sample(20'd415148, 20'd519888);
    send_sample(20'hFFFFF, 20'h00000);
  endtask

  task automatic test_random_phase(int idle_pct, int n);
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(3))
          0: write_coeffs(48'($urandom) << 16 | 48'($urandom), {$urandom, 16'($urandom)},
                          {$urandom, 16'($urandom)}, {$urandom, 16'($urandom)});
          1: typical_coeffs();
          default: jitter_coeffs();
        endcase
      end
      if (i == n / 2) wait_drain();
      random_sample();
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) coeff_regs[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_phase(9, 700);
    test_random_phase(78, 600);
    test_random_phase(0, 700);
    wait_drain();
    if (mismatches == 0) begin
      $display("PASS pressure_temperature_compensation_top");
    end else begin
      $display("FAIL pressure_temperature_compensation_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ptc_pkg.sv
hdl/ptc_mul.sv
hdl/ptc_div.sv
hdl/ptc_core.sv
hdl/pressure_temperature_compensation_top.sv
sim/tb.sv
